/* sv/edd_pkg.sv */
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types, sizes and helpers for the error-diffusion dither unit.
// ----------------------------------------------------------------------------
package edd_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ERR_W      = 9;
    localparam int GREY_W     = 8;
    localparam int CFG_W      = 8;
    localparam int PROD_W     = 12;
    localparam int SUM_W      = 11;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 8'd100;

    typedef logic signed [ERR_W-1:0] err_t;

    // One pixel as it leaves the front stage.
    typedef struct packed {
        logic [GREY_W-1:0] grey;
        logic              frame_start;
        logic              first_row;
        logic              last;
        logic [COL_W-1:0]  col;
    } pix_t;

    // Line buffer write port.
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        err_t             data;
    } lb_wr_t;

    // Divide by 16, truncating toward zero.
    function automatic err_t div16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        logic signed [PROD_W-1:0] q;
        biased = p + (p[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
        q      = biased >>> 4;
        return q[ERR_W-1:0];
    endfunction

endpackage

/* sv/error_diffusion_dither_unit.sv */
// ----------------------------------------------------------------------------
// error_diffusion_dither_unit
// Floyd-Steinberg dither of an 8-bit grey raster stream down to 1 bit/pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one dithered pixel per clock while
// m_tready is high. Each pixel passes the front register, where its column is
// assigned and its line-buffer entry is read, then the diffusion stage, whose
// result lands in the output register. Throughput is one beat per cycle while
// m_tready is high, set by the single write port of the 128-entry line buffer;
// the row-end write is deferred into the next pixel's slot. Assert s_tuser on
// the first pixel of every frame; the first row then sees no error from
// above. Change image_width only while the stream is idle. Widths of 0 read as
// 1, widths above 128 read as 128. m_tlast marks the last pixel of each row.
// ----------------------------------------------------------------------------
module error_diffusion_dither_unit
    import edd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,   // image_width
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,       // [7:0] grey
    input  logic             s_tuser,       // frame_start
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,       // [0] white, [7:1] zero
    output logic             m_tlast        // row_end
);

    logic [CFG_W-1:0] width_reg;
    logic [COL_W-1:0] col_reg;
    logic             fr_reg;
    logic             s1_valid_reg;
    pix_t             s1_reg;
    logic             m_valid_reg, m_white_reg, m_last_reg;

    logic             accept, fire;
    logic [CFG_W-1:0] w_eff;
    logic [COL_W-1:0] x;
    logic             last_x, first_row;
    pix_t             pix_next;
    lb_wr_t           wr;
    err_t             lb_data;
    logic             lb_vld, white;

    // Advance the diffusion stage whenever the output register frees up.
    assign fire     = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    // Front stage: column and row tracking, independent of pixel values.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = CFG_W'(1);
        end else if (width_reg > CFG_W'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        x         = s_tuser ? '0 : col_reg;
        first_row = s_tuser ? 1'b1 : fr_reg;
        last_x    = (CFG_W'(x) + CFG_W'(1)) >= w_eff;
        pix_next  = '{grey: s_tdata, frame_start: s_tuser, first_row: first_row,
                      last: last_x, col: x};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            fr_reg       <= 1'b1;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg      <= last_x ? '0 : x + COL_W'(1);
                fr_reg       <= last_x ? 1'b0 : first_row;
                s1_valid_reg <= 1'b1;
            end else if (fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the front register: hold while stalled.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= pix_next;
        end
    end

    // Read the entry above at accept time; the read data waits with the pixel.
    edd_linebuf u_linebuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (x),
        .wr      (wr),
        .rd_data (lb_data),
        .rd_vld  (lb_vld)
    );

    edd_diffuse u_diffuse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .pix     (s1_reg),
        .lb_data (lb_data),
        .lb_vld  (lb_vld),
        .wr      (wr),
        .white   (white)
    );

    // Output register: parts the diffusion stage from the downstream stall.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_white_reg <= white;
            m_last_reg  <= s1_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, m_white_reg};
    assign m_tlast  = m_last_reg;

endmodule

/* sv/edd_linebuf.sv */
// ----------------------------------------------------------------------------
// edd_linebuf
// One-line error buffer: single write port, registered read with forwarding
// of a same-cycle write, and per-entry valid bits that flag unwritten entries.
// ----------------------------------------------------------------------------
module edd_linebuf
    import edd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  lb_wr_t           wr,
    output err_t             rd_data,
    output logic             rd_vld
);

    err_t                 mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] vld_reg;
    err_t                 rd_data_reg;
    logic                 rd_vld_reg;
    logic                 fwd_hit;

    assign fwd_hit = wr.en && (wr.addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= fwd_hit ? wr.data : mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr] || fwd_hit;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_vld  = rd_vld_reg;

endmodule

/* sv/edd_diffuse.sv */
// ----------------------------------------------------------------------------
// edd_diffuse
// Quantize one corrected pixel and spread its error to the neighbors; holds
// the right carry, the two pending below sums and a deferred row-end write.
// ----------------------------------------------------------------------------
module edd_diffuse
    import edd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   fire,
    input  pix_t   pix,
    input  err_t   lb_data,
    input  logic   lb_vld,
    output lb_wr_t wr,
    output logic   white
);

    err_t   carry_reg, pl_reg, ph_reg;
    lb_wr_t dfr_reg;

    err_t carry, pl, ph, above;
    logic signed [SUM_W-1:0]  v, e_wide;
    err_t                     e;
    logic signed [PROD_W-1:0] e_ext;
    err_t s7, s3, s5, s1, here_sum;

    always_comb begin
        // Frame start clears the carries before this pixel.
        carry = pix.frame_start ? '0 : carry_reg;
        pl    = pix.frame_start ? '0 : pl_reg;
        ph    = pix.frame_start ? '0 : ph_reg;

        if (pix.first_row) begin
            above = '0;
        end else if (dfr_reg.en && (dfr_reg.addr == pix.col)) begin
            above = dfr_reg.data;
        end else if (lb_vld) begin
            above = lb_data;
        end else begin
            above = '0;
        end

        v      = $signed({3'b000, pix.grey}) + SUM_W'(carry) + SUM_W'(above);
        white  = (v >= SUM_W'(128));
        e_wide = white ? (v - SUM_W'(255)) : v;
        e      = e_wide[ERR_W-1:0];
        e_ext  = PROD_W'(e);

        s7 = div16(e_ext * PROD_W'(7));
        s3 = div16(e_ext * PROD_W'(3));
        s5 = div16(e_ext * PROD_W'(5));
        s1 = div16(e_ext);
        here_sum = ph + s5;

        // Column zero writes nothing of its own: flush the deferred entry.
        if (pix.col != '0) begin
            wr.en   = fire;
            wr.addr = pix.col - COL_W'(1);
            wr.data = pl + s3;
        end else begin
            wr.en   = fire && dfr_reg.en;
            wr.addr = dfr_reg.addr;
            wr.data = dfr_reg.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
            pl_reg    <= '0;
            ph_reg    <= '0;
            dfr_reg   <= '0;
        end else if (fire) begin
            if (pix.last) begin
                // Row end: hold the below write for the next pixel's free slot.
                dfr_reg   <= '{en: 1'b1, addr: pix.col, data: here_sum};
                carry_reg <= '0;
                pl_reg    <= '0;
                ph_reg    <= '0;
            end else begin
                if (pix.col == '0) begin
                    dfr_reg.en <= 1'b0;
                end
                carry_reg <= s7;
                pl_reg    <= here_sum;
                ph_reg    <= s1;
            end
        end
    end

endmodule
